// ===== hdl/vfr_pkg.sv =====
// vfr_pkg: frame layout, marker bytes, scaling constants and result types
// for the velocity frame receiver; used by every module under hdl
package vfr_pkg;

  localparam int unsigned PosW     = 5;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned MilliW   = 27;
  localparam int unsigned ProdW    = 26;
  localparam int unsigned ResultW  = 3 * MilliW + 2 * ByteW;
  localparam int unsigned TdataW   = ((ResultW + 7) / 8) * 8;

  // frame positions
  localparam logic [PosW-1:0] PosS      = 5'd0;
  localparam logic [PosW-1:0] PosT      = 5'd1;
  localparam logic [PosW-1:0] PosVxHi   = 5'd2;
  localparam logic [PosW-1:0] PosVxLo   = 5'd3;
  localparam logic [PosW-1:0] PosVxFrH  = 5'd4;
  localparam logic [PosW-1:0] PosVxFrL  = 5'd5;
  localparam logic [PosW-1:0] PosVyHi   = 5'd6;
  localparam logic [PosW-1:0] PosVyLo   = 5'd7;
  localparam logic [PosW-1:0] PosVyFrH  = 5'd8;
  localparam logic [PosW-1:0] PosVyFrL  = 5'd9;
  localparam logic [PosW-1:0] PosWHi    = 5'd10;
  localparam logic [PosW-1:0] PosWLo    = 5'd11;
  localparam logic [PosW-1:0] PosWFrH   = 5'd12;
  localparam logic [PosW-1:0] PosWFrL   = 5'd13;
  localparam logic [PosW-1:0] PosCks    = 5'd14;
  localparam logic [PosW-1:0] PosLink   = 5'd15;
  localparam logic [PosW-1:0] PosMode   = 5'd16;
  localparam logic [PosW-1:0] PosE      = 5'd17;
  localparam logic [PosW-1:0] PosN      = 5'd18;
  localparam logic [PosW-1:0] PosD      = 5'd19;

  // marker bytes
  localparam logic [ByteW-1:0] CharS = 8'h53;
  localparam logic [ByteW-1:0] CharT = 8'h54;
  localparam logic [ByteW-1:0] CharE = 8'h45;
  localparam logic [ByteW-1:0] CharN = 8'h4E;
  localparam logic [ByteW-1:0] CharD = 8'h44;

  // milli scaling: whole * 1000 + frac - 100000
  localparam logic [9:0]        MilliScale  = 10'd1000;
  localparam logic [MilliW-1:0] MilliOffset = 27'd100000;

  // first member sits in the highest bits, so vx_milli lands lowest
  typedef struct packed {
    logic [ByteW-1:0]         drive_mode;
    logic [ByteW-1:0]         link_byte;
    logic signed [MilliW-1:0] w_milli;
    logic signed [MilliW-1:0] vy_milli;
    logic signed [MilliW-1:0] vx_milli;
  } vfr_result_t;

  typedef struct packed {
    logic        valid;
    vfr_result_t data;
  } vfr_res_beat_t;

endpackage

// ===== hdl/vfr_frame_parser.sv =====
// vfr_frame_parser: frame position tracking, marker checks, running checksum
// and per-axis milli decode; depends on vfr_pkg
module vfr_frame_parser
  import vfr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                beat_i,
  input  logic [ByteW-1:0]    byte_i,
  output vfr_res_beat_t       res_o
);

  logic [PosW-1:0]   pos_q, pos_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic [ByteW-1:0]  cks_q, link_q, mode_q;
  logic [ByteW-1:0]  hi_int_q, lo_int_q, hi_frac_q;
  logic [MilliW-1:0] vx_q, vy_q, w_q;
  logic              acc;
  logic              take;
  logic [15:0]       whole;
  logic [15:0]       frac;
  logic [ProdW-1:0]  prod;
  logic [MilliW-1:0] decoded;

  always_comb begin
    case (pos_q)
      PosS:    acc = (byte_i == CharS);
      PosT:    acc = (byte_i == CharT);
      PosE:    acc = (byte_i == CharE);
      PosN:    acc = (byte_i == CharN);
      PosD:    acc = (byte_i == CharD);
      default: acc = pos_q inside {[PosVxHi:PosMode]};
    endcase
  end

  assign take = beat_i && acc;

  // bad marker or stray position drops back to the start
  always_comb begin
    pos_d = pos_q;
    if (beat_i) begin
      if (!acc || pos_q == PosD) begin
        pos_d = PosS;
      end else begin
        pos_d = pos_q + 5'd1;
      end
    end
  end

  // checksum over the twelve velocity bytes, restarted by the first one
  always_comb begin
    sum_d = sum_q;
    if (take) begin
      if (pos_q == PosVxHi) begin
        sum_d = byte_i;
      end else if (pos_q inside {[PosVxLo:PosWFrL]}) begin
        sum_d = sum_q + byte_i;
      end
    end
  end

  assign whole   = {hi_int_q, lo_int_q};
  assign frac    = {hi_frac_q, byte_i};
  assign prod    = ProdW'(whole) * ProdW'(MilliScale);
  assign decoded = MilliW'(prod) + MilliW'(frac) - MilliOffset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosS;
      sum_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      case (pos_q)
        PosVxHi, PosVyHi, PosWHi:    hi_int_q  <= byte_i;
        PosVxLo, PosVyLo, PosWLo:    lo_int_q  <= byte_i;
        PosVxFrH, PosVyFrH, PosWFrH: hi_frac_q <= byte_i;
        PosVxFrL:                    vx_q      <= decoded;
        PosVyFrL:                    vy_q      <= decoded;
        PosWFrL:                     w_q       <= decoded;
        PosCks:                      cks_q     <= byte_i;
        PosLink:                     link_q    <= byte_i;
        PosMode:                     mode_q    <= byte_i;
        default: ;
      endcase
    end
  end

  assign res_o.valid           = take && (pos_q == PosD) && (sum_q == cks_q);
  assign res_o.data.vx_milli   = vx_q;
  assign res_o.data.vy_milli   = vy_q;
  assign res_o.data.w_milli    = w_q;
  assign res_o.data.link_byte  = link_q;
  assign res_o.data.drive_mode = mode_q;

  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosD)
    else $error("frame position out of range");

  a_emit_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (pos_q == PosD) && (byte_i == CharD))
    else $error("result outside the closing byte");

  a_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |=> (pos_q == PosS))
    else $error("position not restarted after a good frame");

endmodule

// ===== hdl/vfr_out_buffer.sv =====
// vfr_out_buffer: two-slot result buffer that registers the output beat and
// keeps the frame side free of the downstream ready; depends on vfr_pkg
module vfr_out_buffer
  import vfr_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vfr_res_beat_t push_i,
  output logic          room_o,
  output logic          valid_o,
  input  logic          ready_i,
  output vfr_result_t   data_o
);

  logic [1:0]  count_q;
  vfr_result_t slot0_q, slot1_q;
  logic        pop;

  assign pop     = (count_q != 2'd0) && ready_i;
  assign room_o  = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = slot0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else if (push_i.valid && !pop) begin
      count_q <= count_q + 2'd1;
    end else if (pop && !push_i.valid) begin
      count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid && !pop) begin
      if (count_q == 2'd0) begin
        slot0_q <= push_i.data;
      end else begin
        slot1_q <= push_i.data;
      end
    end else if (pop && !push_i.valid) begin
      slot0_q <= slot1_q;
    end else if (pop && push_i.valid) begin
      if (count_q == 2'd1) begin
        slot0_q <= push_i.data;
      end else begin
        slot0_q <= slot1_q;
        slot1_q <= push_i.data;
      end
    end
  end

  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("result buffer count overflow");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> (count_q != 2'd2))
    else $error("result pushed into a full buffer");

endmodule

// ===== hdl/velocity_frame_receiver.sv =====
// velocity_frame_receiver: top level, input beat register, frame parser and
// result buffer; depends on vfr_pkg, vfr_frame_parser, vfr_out_buffer
//
//   channel   dir  payload (tdata, lowest bit first)                 beat
//   s_axis    in   rx_byte[7:0]                                      one serial byte
//   m_axis    out  vx_milli, vy_milli, w_milli, link_byte,           one good frame
//                  drive_mode, 7 zero pad bits (104 bits)
//
// one byte a cycle while a result slot is free, parsed from the input register
// the closing 'D' beat passes the input register, a result slot sets m_axis_tvalid
// the single 16 x 10 multiply of the axis decode sets the cycle path
// rst_ni clears the frame position, checksum and both handshake stages
// a stalled m_axis fills the two result slots, the parser then holds the next
// byte in the input register and s_axis_tready drops
module velocity_frame_receiver
  import vfr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // rx_byte[7:0]
  input  logic [ByteW-1:0]  s_axis_tdata,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // vx_milli[26:0], vy_milli[53:27], w_milli[80:54], link_byte[88:81],
  // drive_mode[96:89], zeros[103:97]
  output logic [TdataW-1:0] m_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready
);

  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             room;
  logic             advance;
  logic             s_take;
  vfr_res_beat_t    res;
  vfr_result_t      out_data;

  // byte in the input register moves on whenever a result slot is free
  assign advance       = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || room;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  vfr_frame_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (advance),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  vfr_out_buffer u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_data)
  );

  // pad the packed result up to whole bytes
  assign m_axis_tdata = {(TdataW - ResultW)'(0), out_data};

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for velocity_frame_receiver, serial bytes in,
// decoded velocity frames out; depends on vfr_pkg and the rtl under hdl
module tb_top
  import vfr_pkg::*;
();

  localparam int unsigned FrameLen    = 20;
  localparam int unsigned HoldCycles  = 160;
  localparam int unsigned LimitCycles = 400000;
  localparam int unsigned ReportMax   = 10;

  typedef logic [ByteW-1:0] rx_byte_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic [ByteW-1:0]  s_tdata  = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [TdataW-1:0] m_tdata;
  logic              m_tvalid;
  logic              m_ready  = 1'b0;

  // idle rates in percent, set per phase
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        rx_holding  = 1'b0;
  event        rx_hold_ev;

  // frame tracker state: next position and bytes taken so far
  logic [PosW-1:0] rx_pos = PosS;
  rx_byte_t        rx_frame [FrameLen];

  vfr_result_t expected_frames [$];

  int unsigned mismatches   = 0;
  int unsigned frames_seen  = 0;
  int unsigned frames_good  = 0;
  int unsigned frames_lost  = 0;
  int unsigned bytes_sent   = 0;

  velocity_frame_receiver DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_tdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_ready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // frame tracker: mirrors the byte-by-byte parse and queues decoded frames
  // ---------------------------------------------------------------------------

  function automatic void clear_frame();
    for (int i = 0; i < FrameLen; i++) rx_frame[i] = '0;
    rx_pos = PosS;
  endfunction

  // whole * 1000 + frac - 100000, kept to the 27-bit output width
  function automatic logic [MilliW-1:0] milli_of(input int base);
    int whole;
    int frac;
    int v;
    whole = int'({rx_frame[base], rx_frame[base+1]});
    frac  = int'({rx_frame[base+2], rx_frame[base+3]});
    v     = whole * 1000 + frac - 100000;
    return v[MilliW-1:0];
  endfunction

  function automatic void take_rx_byte(input rx_byte_t b);
    logic        ok;
    rx_byte_t    sum;
    vfr_result_t r;
    case (rx_pos)
      PosS: ok = (b == CharS);
      PosT: ok = (b == CharT);
      PosE: ok = (b == CharE);
      PosN: ok = (b == CharN);
      PosD: ok = (b == CharD);
      // payload takes anything; positions past the trailer never occur
      default: ok = (rx_pos < PosE);
    endcase
    if (!ok) begin
      // the offending byte is dropped, not retried as a start marker
      clear_frame();
      return;
    end
    rx_frame[rx_pos] = b;
    if (rx_pos != PosD) begin
      rx_pos = rx_pos + 1'b1;
      return;
    end
    rx_pos = PosS;
    sum = '0;
    for (int i = int'(PosVxHi); i <= int'(PosWFrL); i++) sum = sum + rx_frame[i];
    if (sum != rx_frame[PosCks]) begin
      frames_lost++;
      return;
    end
    r.vx_milli   = milli_of(int'(PosVxHi));
    r.vy_milli   = milli_of(int'(PosVyHi));
    r.w_milli    = milli_of(int'(PosWHi));
    r.link_byte  = rx_frame[PosLink];
    r.drive_mode = rx_frame[PosMode];
    expected_frames.push_back(r);
    frames_good++;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void note_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    mismatches++;
    if (mismatches <= ReportMax)
      $display("mismatch %0s: expected %0h, got %0h", what, want, got);
  endfunction

  function automatic void check_frame(input logic [TdataW-1:0] beat);
    vfr_result_t got;
    vfr_result_t want;
    got = vfr_result_t'(beat[ResultW-1:0]);
    frames_seen++;
    if (expected_frames.size() == 0) begin
      note_mismatch("unexpected frame beat", '0, beat[63:0]);
      return;
    end
    want = expected_frames.pop_front();
    if (got.vx_milli != want.vx_milli)
      note_mismatch("vx_milli", 64'(want.vx_milli), 64'(got.vx_milli));
    if (got.vy_milli != want.vy_milli)
      note_mismatch("vy_milli", 64'(want.vy_milli), 64'(got.vy_milli));
    if (got.w_milli != want.w_milli)
      note_mismatch("w_milli", 64'(want.w_milli), 64'(got.w_milli));
    if (got.link_byte != want.link_byte)
      note_mismatch("link_byte", 64'(want.link_byte), 64'(got.link_byte));
    if (got.drive_mode != want.drive_mode)
      note_mismatch("drive_mode", 64'(want.drive_mode), 64'(got.drive_mode));
    if (beat[TdataW-1:ResultW] != '0)
      note_mismatch("pad bits", '0, 64'(beat[TdataW-1:ResultW]));
  endfunction

  // values sampled at the edge are the ones from before it
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_ready) check_frame(m_tdata);
  end

  // output side: random stalls, or a long hold when asked
  always @(posedge clk_i) begin
    if (rx_holding) m_ready <= 1'b0;
    else            m_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // long output hold, counted here so the sender keeps going meanwhile
  initial begin
    forever begin
      @(rx_hold_ev);
      @(posedge clk_i);
      rx_holding <= 1'b1;
      for (int n = 0; n < HoldCycles; n++) @(posedge clk_i);
      rx_holding <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // one beat on the input side, with an optional random gap first
  task automatic send_byte(input rx_byte_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    take_rx_byte(b);
  endtask

  // any byte except the marker given
  function automatic rx_byte_t wrong_byte(input rx_byte_t marker);
    rx_byte_t b;
    // a start marker in the wrong place is the interesting case
    if (marker != CharS && $urandom_range(2) == 0) return CharS;
    b = rx_byte_t'($urandom_range(255));
    if (b == marker) b = ~b;
    return b;
  endfunction

  // full frame, or one cut short by a bad byte at marker position cut_at
  // (cut_at < 0 sends the whole frame)
  task automatic send_frame(input rx_byte_t body [12], input rx_byte_t link,
                            input rx_byte_t mode, input bit bad_sum, input int cut_at);
    rx_byte_t bytes [FrameLen];
    rx_byte_t sum;
    sum = '0;
    for (int i = 0; i < 12; i++) begin
      bytes[PosVxHi + i] = body[i];
      sum = sum + body[i];
    end
    bytes[PosS]    = CharS;
    bytes[PosT]    = CharT;
    bytes[PosCks]  = bad_sum ? sum + rx_byte_t'($urandom_range(255, 1)) : sum;
    bytes[PosLink] = link;
    bytes[PosMode] = mode;
    bytes[PosE]    = CharE;
    bytes[PosN]    = CharN;
    bytes[PosD]    = CharD;
    if (cut_at >= 0) bytes[cut_at] = wrong_byte(bytes[cut_at]);
    for (int i = 0; i < FrameLen; i++) begin
      send_byte(bytes[i]);
      bytes_sent++;
      if (i == cut_at) break;
    end
  endtask

  // payload bytes, with the all-zero and all-one extremes now and then
  function automatic rx_byte_t pick_byte();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return rx_byte_t'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random_frame(input bit bad_sum, input int cut_at);
    rx_byte_t body [12];
    for (int i = 0; i < 12; i++) body[i] = pick_byte();
    send_frame(body, pick_byte(), pick_byte(), bad_sum, cut_at);
  endtask

  // largest and smallest decoded values, link and mode at both ends
  task automatic test_value_extremes();
    rx_byte_t body [12];
    for (int i = 0; i < 12; i++) body[i] = '1;
    send_frame(body, '0, '1, 1'b0, -1);
    for (int i = 0; i < 12; i++) body[i] = '0;
    send_frame(body, '1, '0, 1'b0, -1);
  endtask

  // checksum mismatch, stray markers, wrong closing byte, then recovery
  task automatic test_frame_errors();
    rx_byte_t body [12];
    for (int i = 0; i < 12; i++) body[i] = rx_byte_t'(8'h11 * i + 8'h07);
    send_frame(body, 8'h5A, 8'hA5, 1'b1, -1);
    // second 'S' aborts at position 1 and is dropped, so 'T' is stray too
    send_byte(CharS);
    send_byte(CharS);
    send_byte(CharT);
    bytes_sent += 3;
    send_frame(body, 8'h01, 8'h80, 1'b0, int'(PosD));
    send_frame(body, 8'h01, 8'h80, 1'b0, -1);
  endtask

  // mixed traffic: mostly good frames, some bad sums, cut frames and noise
  task automatic test_random_traffic(input int unsigned n_bytes, input int unsigned n_frames);
    int unsigned byte_goal;
    int unsigned frame_goal;
    int unsigned pick;
    byte_goal  = bytes_sent + n_bytes;
    frame_goal = frames_good + n_frames;
    while (bytes_sent < byte_goal || frames_good < frame_goal) begin
      pick = $urandom_range(99);
      if (pick < 68) begin
        send_random_frame(1'b0, -1);
      end else if (pick < 80) begin
        send_random_frame(1'b1, -1);
      end else if (pick < 95) begin
        case ($urandom_range(4))
          0:       send_random_frame(1'b0, int'(PosS));
          1:       send_random_frame(1'b0, int'(PosT));
          2:       send_random_frame(1'b0, int'(PosE));
          3:       send_random_frame(1'b0, int'(PosN));
          default: send_random_frame(1'b0, int'(PosD));
        endcase
      end else begin
        // line noise between frames; it never forms a whole frame, so no result comes of it
        repeat ($urandom_range(4, 1)) send_byte(rx_byte_t'($urandom_range(255)));
      end
    end
  endtask

  // output held off long enough for results to back up into the input side
  task automatic test_output_stall();
    -> rx_hold_ev;
    repeat (6) send_random_frame(1'b0, -1);
  endtask

  initial begin
    #(LimitCycles * 12);
    $display("timeout after %0d cycles", LimitCycles);
    $display("status: fail");
    $finish;
  end

  initial begin
    clear_frame();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles lightly, receiver heavily
    tx_idle_pct = 22;
    rx_idle_pct = 76;
    test_value_extremes();
    test_frame_errors();
    test_random_traffic(120, 4);

    // and the other way round
    tx_idle_pct = 76;
    rx_idle_pct = 22;
    test_random_traffic(120, 4);

    // back to back on both sides, with one long output hold
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_output_stall();
    test_random_traffic(120, 4);

    s_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("sent %0d frame bytes: %0d good frames, %0d bad-checksum frames, %0d checked",
             bytes_sent, frames_good, frames_lost, frames_seen);
    $display("phases: light and heavy idling each side, back to back, %0d-cycle output hold",
             HoldCycles);
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d frames still expected", mismatches,
               expected_frames.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
